// File: hdl/wgm_pkg.sv
// wgm_pkg: shared types, command codes and character helpers of the wildcard glob matcher
// no dependencies; used by every file in hdl
package wgm_pkg;

	typedef logic [7:0] byte_t;

	// command codes of an input item
	typedef logic [1:0] cmd_t;
	localparam cmd_t CMD_APPEND  = 2'd0;
	localparam cmd_t CMD_SUBJECT = 2'd1;
	localparam cmd_t CMD_END     = 2'd2;
	localparam cmd_t CMD_CLEAR   = 2'd3;

	// pattern wildcards
	localparam byte_t STAR_CHAR  = 8'h2A;
	localparam byte_t QMARK_CHAR = 8'h3F;

	// ascii folding range
	localparam byte_t UPPER_A    = 8'h41;
	localparam byte_t UPPER_Z    = 8'h5A;
	localparam byte_t CASE_DELTA = 8'h20;

	// input item
	typedef struct packed {
		cmd_t  cmd;
		byte_t ch;
		logic  last;
	} in_item_t;

	// result item
	typedef struct packed {
		logic matched;
		logic pattern_overflow;
	} out_item_t;

	// pattern store write control
	typedef struct packed {
		logic  append;
		logic  clear;
		byte_t ch;
	} pat_ctl_t;

	// fold A-Z to a-z unless compares are exact
	function automatic byte_t fold_char(input byte_t c, input logic case_sensitive);
		byte_t r;
		r = c;
		if (!case_sensitive && c >= UPPER_A && c <= UPPER_Z) begin
			r = c + CASE_DELTA;
		end
		return r;
	endfunction

endpackage

// File: hdl/wgm_pat_store.sv
// wgm_pat_store: pattern byte store with star, question and valid masks, length,
// sticky overflow flag and the closed start vector; uses wgm_pkg
module wgm_pat_store #(
	parameter int PAT_LEN = 32
) (
	input  logic              clk,
	input  logic              arst_n,
	input  wgm_pkg::pat_ctl_t ctl,
	output wgm_pkg::byte_t    pat_byte [PAT_LEN],
	output logic [PAT_LEN-1:0] star_mask,
	output logic [PAT_LEN-1:0] qmark_mask,
	output logic [PAT_LEN-1:0] valid_mask,
	output logic [PAT_LEN:0]   start_vec,
	output logic [$clog2(PAT_LEN+1)-1:0] pat_len,
	output logic              overflow
);

	localparam int LW = $clog2(PAT_LEN + 1);

	wgm_pkg::byte_t           store_q [PAT_LEN];
	logic [PAT_LEN-1:0]       star_q;
	logic [PAT_LEN-1:0]       qmark_q;
	logic [PAT_LEN-1:0]       valid_q;
	logic [PAT_LEN:0]         start_q;
	logic [LW-1:0]            len_q;
	logic                     ovf_q;
	logic                     full;
	logic                     wr;
	logic                     is_star;

	assign full    = (len_q == LW'(PAT_LEN));
	assign wr      = ctl.append && !full;
	assign is_star = (ctl.ch == wgm_pkg::STAR_CHAR);

	// pattern bytes, written at the current length
	always_ff @(posedge clk) begin
		for (int i = 0; i < PAT_LEN; i++) begin
			if (wr && len_q == LW'(i)) begin
				store_q[i] <= ctl.ch;
			end
		end
	end

	// per-position flags, length, overflow and start vector
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			star_q  <= '0;
			qmark_q <= '0;
			valid_q <= '0;
			start_q <= (PAT_LEN+1)'(1);
			len_q   <= '0;
			ovf_q   <= 1'b0;
		end else if (ctl.clear) begin
			star_q  <= '0;
			qmark_q <= '0;
			valid_q <= '0;
			start_q <= (PAT_LEN+1)'(1);
			len_q   <= '0;
			ovf_q   <= 1'b0;
		end else if (ctl.append) begin
			if (full) begin
				ovf_q <= 1'b1;
			end else begin
				len_q <= len_q + LW'(1);
				for (int i = 0; i < PAT_LEN; i++) begin
					if (len_q == LW'(i)) begin
						star_q[i]  <= is_star;
						qmark_q[i] <= (ctl.ch == wgm_pkg::QMARK_CHAR);
						valid_q[i] <= 1'b1;
						// leading stars extend the empty-prefix closure
						if (start_q[i] && is_star) begin
							start_q[i+1] <= 1'b1;
						end
					end
				end
			end
		end
	end

	assign pat_byte   = store_q;
	assign star_mask  = star_q;
	assign qmark_mask = qmark_q;
	assign valid_mask = valid_q;
	assign start_vec  = start_q;
	assign pat_len    = len_q;
	assign overflow   = ovf_q;

endmodule

// File: hdl/wgm_nfa.sv
// wgm_nfa: bit-parallel active position vector, one subject character per step
// with star closure by carry propagation; uses wgm_pkg
module wgm_nfa #(
	parameter int PAT_LEN = 32
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               fire,
	input  wgm_pkg::in_item_t  item,
	input  logic               case_sensitive,
	input  wgm_pkg::byte_t     pat_byte [PAT_LEN],
	input  logic [PAT_LEN-1:0] star_mask,
	input  logic [PAT_LEN-1:0] qmark_mask,
	input  logic [PAT_LEN-1:0] valid_mask,
	input  logic [PAT_LEN:0]   start_vec,
	input  logic [$clog2(PAT_LEN+1)-1:0] pat_len,
	output logic               matched
);

	logic [PAT_LEN:0]   active_q;
	logic               sip_q;
	logic [PAT_LEN:0]   cur;
	logic [PAT_LEN:0]   star_ext;
	logic [PAT_LEN:0]   step_ext;
	logic [PAT_LEN:0]   nx;
	logic [PAT_LEN:0]   closed;
	logic [PAT_LEN-1:0] hit;
	wgm_pkg::byte_t     ch_f;

	// vector the current character steps from (already closed)
	assign cur = sip_q ? active_q : start_vec;

	// per-position character compare
	assign ch_f = wgm_pkg::fold_char(item.ch, case_sensitive);
	always_comb begin
		for (int i = 0; i < PAT_LEN; i++) begin
			hit[i] = qmark_mask[i] ||
				(wgm_pkg::fold_char(pat_byte[i], case_sensitive) == ch_f);
		end
	end

	// stars hold their position, matching positions move one on
	assign star_ext = {1'b0, star_mask};
	assign step_ext = {1'b0, valid_mask & ~star_mask & hit};
	assign nx       = (cur & star_ext) | ((cur & step_ext) << 1);

	// closure: an active star run also activates the position past it
	assign closed = nx | (((nx & star_ext) + star_ext) ^ star_ext);

	// match bit at the pattern end
	always_comb begin
		if (item.cmd == wgm_pkg::CMD_SUBJECT) begin
			matched = closed[pat_len];
		end else begin
			matched = cur[pat_len];
		end
	end

	// subject progress
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q <= (PAT_LEN+1)'(1);
			sip_q    <= 1'b0;
		end else if (fire) begin
			if (item.cmd == wgm_pkg::CMD_SUBJECT && !item.last) begin
				active_q <= closed;
				sip_q    <= 1'b1;
			end else begin
				sip_q    <= 1'b0;
			end
		end
	end

endmodule

// File: hdl/wildcard_glob_matcher.sv
// wildcard_glob_matcher: top level with input stage, pattern store, position vector
// and result register; uses wgm_pkg, wgm_pat_store and wgm_nfa
//
//   channel | signals                       | moves
//   --------+-------------------------------+------------------------------------
//   item    | item_valid item_ready item    | command, character, last flag
//   res     | res_valid res_ready res       | matched, pattern_overflow
//   cfg     | cfg_valid cfg_ready cfg_data  | case_sensitive register
//
// one item per cycle while no result is stalled; an accepted item is held in the input register,
// and its result is then written into the result register
// reset: case_sensitive = 1, pattern empty, no overflow, no subject in progress
// a stalled result stalls only an item that itself makes a result; others pass
module wildcard_glob_matcher #(
	parameter int PAT_LEN = 32
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               item_valid,
	output logic               item_ready,
	input  wgm_pkg::in_item_t  item,
	output logic               res_valid,
	input  logic               res_ready,
	output wgm_pkg::out_item_t res,
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic               cfg_data
);

	localparam int LW = $clog2(PAT_LEN + 1);

	logic               cs_q;
	logic               valid_s1;
	wgm_pkg::in_item_t  item_s1;
	logic               res_valid_q;
	wgm_pkg::out_item_t res_q;
	logic               produce;
	logic               fire;
	logic               matched;
	wgm_pkg::pat_ctl_t  pctl;
	wgm_pkg::byte_t     pat_byte [PAT_LEN];
	logic [PAT_LEN-1:0] star_mask;
	logic [PAT_LEN-1:0] qmark_mask;
	logic [PAT_LEN-1:0] valid_mask;
	logic [PAT_LEN:0]   start_vec;
	logic [LW-1:0]      pat_len;
	logic               overflow;

	// configuration register
	assign cfg_ready = 1'b1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cs_q <= 1'b1;
		end else if (cfg_valid && cfg_ready) begin
			cs_q <= cfg_data;
		end
	end

	// stage handshake
	assign produce = (item_s1.cmd == wgm_pkg::CMD_END) ||
		(item_s1.cmd == wgm_pkg::CMD_SUBJECT && item_s1.last);
	assign fire       = valid_s1 && (!produce || !res_valid_q || res_ready);
	assign item_ready = !valid_s1 || fire;

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (item_ready) begin
			valid_s1 <= item_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (item_valid && item_ready) begin
			item_s1 <= item;
		end
	end

	// pattern store control
	always_comb begin
		pctl.append = fire && (item_s1.cmd == wgm_pkg::CMD_APPEND);
		pctl.clear  = fire && (item_s1.cmd == wgm_pkg::CMD_CLEAR);
		pctl.ch     = item_s1.ch;
	end

	wgm_pat_store #(
		.PAT_LEN(PAT_LEN)
	) u_pat_store (
		.clk       (clk),
		.arst_n    (arst_n),
		.ctl       (pctl),
		.pat_byte  (pat_byte),
		.star_mask (star_mask),
		.qmark_mask(qmark_mask),
		.valid_mask(valid_mask),
		.start_vec (start_vec),
		.pat_len   (pat_len),
		.overflow  (overflow)
	);

	wgm_nfa #(
		.PAT_LEN(PAT_LEN)
	) u_nfa (
		.clk           (clk),
		.arst_n        (arst_n),
		.fire          (fire),
		.item          (item_s1),
		.case_sensitive(cs_q),
		.pat_byte      (pat_byte),
		.star_mask     (star_mask),
		.qmark_mask    (qmark_mask),
		.valid_mask    (valid_mask),
		.start_vec     (start_vec),
		.pat_len       (pat_len),
		.matched       (matched)
	);

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (fire && produce) begin
			res_valid_q <= 1'b1;
		end else if (res_ready) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (fire && produce) begin
			res_q.matched          <= matched;
			res_q.pattern_overflow <= overflow;
		end
	end

	assign res_valid = res_valid_q;
	assign res       = res_q;

endmodule

// File: hdl/wgm_checker.sv
// wgm_checker: port-level assertions on the wildcard glob matcher
// uses wgm_pkg; attached to wildcard_glob_matcher by the bind at the end of this file
module wgm_checker (
	input logic               clk,
	input logic               arst_n,
	input logic               item_valid,
	input logic               item_ready,
	input wgm_pkg::in_item_t  item,
	input logic               res_valid,
	input logic               res_ready,
	input wgm_pkg::out_item_t res
);

	logic acc_end;
	logic acc_clear;

	assign acc_end   = item_valid && item_ready && item.cmd == wgm_pkg::CMD_END;
	assign acc_clear = item_valid && item_ready && item.cmd == wgm_pkg::CMD_CLEAR;

	// a held result keeps its value
	a_res_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_ready |=> res_valid && $stable(res))
		else $error("result changed while stalled");

	// the input side only stalls behind a stalled result
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		!item_ready |-> res_valid && !res_ready)
		else $error("input stalled without output back-pressure");

	// an end item passes the input register and reaches the result register when output flows
	a_end_latency: assert property (@(posedge clk) disable iff (!arst_n)
		acc_end ##1 res_ready |=> res_valid)
		else $error("end item gave no result");

	// empty subject against an empty pattern matches, with no overflow
	a_empty_match: assert property (@(posedge clk) disable iff (!arst_n)
		acc_clear ##1 acc_end ##1 res_ready |=> res_valid && res.matched &&
			!res.pattern_overflow)
		else $error("empty subject after clear did not match");

endmodule

bind wildcard_glob_matcher wgm_checker u_wgm_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.item_valid(item_valid),
	.item_ready(item_ready),
	.item      (item),
	.res_valid (res_valid),
	.res_ready (res_ready),
	.res       (res)
);

// File: bench/wgm_match_checker.sv
// wgm_match_checker: watches the item, result and config channels of the glob matcher,
// predicts each result from its own copy of the pattern and position vector, and compares
// depends on wgm_pkg for the item types, command codes and wildcard bytes
module wgm_match_checker #(
	parameter int PAT_LEN = 32
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               item_valid,
	input  logic               item_ready,
	input  wgm_pkg::in_item_t  item,
	input  logic               res_valid,
	input  logic               res_ready,
	input  wgm_pkg::out_item_t res,
	input  logic               cfg_valid,
	input  logic               cfg_ready,
	input  logic               cfg_data,
	output int                 mismatch_count,
	output int                 results_owed
);
	timeunit 1ns;
	timeprecision 1ps;

	// predicted matcher state, starting at its reset values
	wgm_pkg::byte_t     pat_mem [PAT_LEN] = '{default: '0};
	int                 pat_cnt = 0;
	logic [PAT_LEN:0]   live_pos = (PAT_LEN+1)'(1);
	bit                 mid_subject = 1'b0;
	bit                 ovf_seen = 1'b0;
	bit                 exact_case = 1'b1;
	wgm_pkg::out_item_t owed_q [$];

	// ascii-only case folding when compares are not exact
	function automatic wgm_pkg::byte_t lower_of(input wgm_pkg::byte_t c);
		if (!exact_case && c >= wgm_pkg::UPPER_A && c <= wgm_pkg::UPPER_Z) begin
			return c + wgm_pkg::CASE_DELTA;
		end
		return c;
	endfunction

	// an active star also makes the position after it active
	function automatic logic [PAT_LEN:0] star_closure(input logic [PAT_LEN:0] v);
		int i;
		for (i = 0; i < pat_cnt; i++) begin
			if (v[i] && pat_mem[i] == wgm_pkg::STAR_CHAR) begin
				v[i + 1] = 1'b1;
			end
		end
		return v;
	endfunction

	// advance the position vector by one subject character
	function automatic logic [PAT_LEN:0] step_positions(input logic [PAT_LEN:0] v,
			input wgm_pkg::byte_t c);
		logic [PAT_LEN:0] nx;
		int i;
		nx = '0;
		v = star_closure(v);
		for (i = 0; i < pat_cnt; i++) begin
			if (v[i]) begin
				if (pat_mem[i] == wgm_pkg::STAR_CHAR) begin
					nx[i] = 1'b1;
				end else if (pat_mem[i] == wgm_pkg::QMARK_CHAR ||
						lower_of(pat_mem[i]) == lower_of(c)) begin
					nx[i + 1] = 1'b1;
				end
			end
		end
		return nx;
	endfunction

	// apply one accepted item, queueing the match it causes, if any
	task automatic take_item(input wgm_pkg::in_item_t it);
		logic [PAT_LEN:0] v;
		wgm_pkg::out_item_t r;
		case (it.cmd)
			wgm_pkg::CMD_APPEND: begin
				if (pat_cnt < PAT_LEN) begin
					pat_mem[pat_cnt] = it.ch;
					pat_cnt++;
				end else begin
					ovf_seen = 1'b1;
				end
				live_pos = (PAT_LEN+1)'(1);
				mid_subject = 1'b0;
			end
			wgm_pkg::CMD_CLEAR: begin
				pat_cnt = 0;
				ovf_seen = 1'b0;
				live_pos = (PAT_LEN+1)'(1);
				mid_subject = 1'b0;
			end
			default: begin
				v = mid_subject ? live_pos : (PAT_LEN+1)'(1);
				if (it.cmd == wgm_pkg::CMD_SUBJECT) begin
					v = step_positions(v, it.ch);
				end
				if (it.cmd == wgm_pkg::CMD_SUBJECT && !it.last) begin
					live_pos = v;
					mid_subject = 1'b1;
				end else begin
					v = star_closure(v);
					r.matched = v[pat_cnt];
					r.pattern_overflow = ovf_seen;
					owed_q.push_back(r);
					live_pos = (PAT_LEN+1)'(1);
					mid_subject = 1'b0;
				end
			end
		endcase
	endtask

	// count a mismatch, report only the first few
	task automatic note_bad(input string what, input logic want, input logic got);
		mismatch_count++;
		if (mismatch_count <= 10) begin
			$display("%0t ns: %s expected %0b got %0b", $time, what, want, got);
		end
	endtask

	// compare one result with the oldest prediction
	task automatic check_result(input wgm_pkg::out_item_t got);
		wgm_pkg::out_item_t want;
		if (owed_q.size() == 0) begin
			mismatch_count++;
			if (mismatch_count <= 10) begin
				$display("%0t ns: result with no prediction, matched %0b overflow %0b",
					$time, got.matched, got.pattern_overflow);
			end
		end else begin
			want = owed_q.pop_front();
			if (got.matched !== want.matched) begin
				note_bad("matched", want.matched, got.matched);
			end
			if (got.pattern_overflow !== want.pattern_overflow) begin
				note_bad("pattern_overflow", want.pattern_overflow, got.pattern_overflow);
			end
		end
	endtask

	// sample all three channels at the rising edge
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			exact_case = 1'b1;
			pat_cnt = 0;
			ovf_seen = 1'b0;
			live_pos = (PAT_LEN+1)'(1);
			mid_subject = 1'b0;
			owed_q.delete();
			results_owed = 0;
			mismatch_count = 0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				exact_case = cfg_data;
			end
			if (item_valid && item_ready) begin
				take_item(item);
			end
			if (res_valid && res_ready) begin
				check_result(res);
			end
			results_owed = owed_q.size();
		end
	end

endmodule

// File: bench/wildcard_glob_matcher_test.sv
// wildcard_glob_matcher_test: drives patterns, subjects and case settings into the
// glob matcher under random idling and gives the verdict; uses wgm_pkg, wgm_match_checker
module wildcard_glob_matcher_test;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int PAT_LEN = 32;
	localparam int SETTLE_CYCLES = 6;
	localparam int HOLD_CYCLES = 120;

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               item_valid = 1'b0;
	logic               item_ready;
	wgm_pkg::in_item_t  item = '0;
	logic               res_valid;
	logic               res_ready = 1'b0;
	wgm_pkg::out_item_t res;
	logic               cfg_valid = 1'b0;
	logic               cfg_ready;
	logic               cfg_data = 1'b0;

	int tx_idle_pct = 34;
	int rx_idle_pct = 50;
	bit hold_req = 1'b0;
	bit hold_done = 1'b0;
	int items_sent = 0;
	int mismatch_count;
	int owed_count;

	wildcard_glob_matcher #(
		.PAT_LEN(PAT_LEN)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.item_valid(item_valid),
		.item_ready(item_ready),
		.item(item),
		.res_valid(res_valid),
		.res_ready(res_ready),
		.res(res),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_data(cfg_data)
	);

	wgm_match_checker #(
		.PAT_LEN(PAT_LEN)
	) match_chk (
		.clk(clk),
		.arst_n(arst_n),
		.item_valid(item_valid),
		.item_ready(item_ready),
		.item(item),
		.res_valid(res_valid),
		.res_ready(res_ready),
		.res(res),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_data(cfg_data),
		.mismatch_count(mismatch_count),
		.results_owed(owed_count)
	);

	// 4 ns clock
	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// run limit
	initial begin
		#2ms;
		$display("Some tests failed");
		$finish;
	end

	// result receiver: random stalls plus one long hold-off on request
	initial begin
		forever begin
			@(negedge clk);
			if (hold_req && !hold_done) begin
				res_ready <= 1'b0;
				repeat (HOLD_CYCLES) @(negedge clk);
				hold_done = 1'b1;
			end
			res_ready <= ($urandom_range(99) >= rx_idle_pct);
		end
	end

	// offer one item after a random gap and wait for it to be taken
	task automatic send_item(input wgm_pkg::cmd_t op, input wgm_pkg::byte_t ch,
			input logic last);
		wgm_pkg::in_item_t it;
		it.cmd = op;
		it.ch = ch;
		it.last = last;
		while ($urandom_range(99) < tx_idle_pct) begin
			item_valid <= 1'b0;
			@(negedge clk);
		end
		item_valid <= 1'b1;
		item <= it;
		do @(posedge clk); while (!item_ready);
		@(negedge clk);
		items_sent++;
	endtask

	// stop offering and wait until every predicted result has come out
	task automatic drain();
		item_valid <= 1'b0;
		while (owed_count != 0) @(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	task automatic write_case_mode(input logic exact);
		cfg_valid <= 1'b1;
		cfg_data <= exact;
		do @(posedge clk); while (!cfg_ready);
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	// mostly a small alphabet so that subjects often match, sometimes any byte
	function automatic wgm_pkg::byte_t text_char();
		if ($urandom_range(9) < 7) begin
			case ($urandom_range(3))
				0: return "a";
				1: return "A";
				2: return "b";
				default: return "B";
			endcase
		end
		return wgm_pkg::byte_t'($urandom_range(255));
	endfunction

	function automatic wgm_pkg::byte_t pattern_char();
		int r;
		r = $urandom_range(99);
		if (r < 30) begin
			return wgm_pkg::STAR_CHAR;
		end else if (r < 45) begin
			return wgm_pkg::QMARK_CHAR;
		end
		return text_char();
	endfunction

	// clear (most of the time), load a pattern, then feed subjects built from it, some of them altered
	task automatic run_sequence(input bit overfill);
		wgm_pkg::byte_t pat [$];
		wgm_pkg::byte_t subj [$];
		wgm_pkg::byte_t c;
		int n, k, j;
		bit end_by_last;
		if ($urandom_range(9) != 0) begin
			send_item(wgm_pkg::CMD_CLEAR, wgm_pkg::byte_t'($urandom_range(255)),
				1'($urandom_range(1)));
		end
		if (overfill) begin
			n = PAT_LEN + $urandom_range(1, 3);
		end else if ($urandom_range(9) == 0) begin
			n = $urandom_range(7, PAT_LEN);
		end else begin
			n = $urandom_range(0, 6);
		end
		for (k = 0; k < n; k++) begin
			c = pattern_char();
			pat.push_back(c);
			send_item(wgm_pkg::CMD_APPEND, c, 1'($urandom_range(1)));
		end
		repeat ($urandom_range(1, 4)) begin
			subj.delete();
			for (k = 0; k < n && k < PAT_LEN; k++) begin
				if (pat[k] == wgm_pkg::STAR_CHAR) begin
					repeat ($urandom_range(0, 3)) subj.push_back(text_char());
				end else if (pat[k] == wgm_pkg::QMARK_CHAR) begin
					subj.push_back(wgm_pkg::byte_t'($urandom_range(255)));
				end else begin
					c = pat[k];
					// flip the case bit now and then
					if ($urandom_range(3) == 0) begin
						c ^= wgm_pkg::CASE_DELTA;
					end
					subj.push_back(c);
				end
			end
			// occasional edit so that near misses show up
			case ($urandom_range(5))
				0: if (subj.size() > 0) subj[$urandom_range(subj.size() - 1)] = text_char();
				1: subj.push_back(text_char());
				2: if (subj.size() > 0) void'(subj.pop_front());
				default: ;
			endcase
			end_by_last = ($urandom_range(4) != 0);
			for (j = 0; j < subj.size(); j++) begin
				send_item(wgm_pkg::CMD_SUBJECT, subj[j],
					end_by_last && j == subj.size() - 1);
			end
			if (!end_by_last || subj.size() == 0) begin
				send_item(wgm_pkg::CMD_END, wgm_pkg::byte_t'($urandom_range(255)),
					1'($urandom_range(1)));
			end
		end
	endtask

	// well-formed sequences with some noise items in between
	task automatic run_phase(input int count);
		int start;
		start = items_sent;
		run_sequence(1'b1);
		while (items_sent - start < count) begin
			if ($urandom_range(99) < 10) begin
				send_item(wgm_pkg::cmd_t'($urandom_range(3)),
					wgm_pkg::byte_t'($urandom_range(255)), 1'($urandom_range(1)));
			end else begin
				run_sequence(1'b0);
			end
		end
	endtask

	// stimulus and verdict
	initial begin
		repeat (2) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// empty pattern against empty and one-character subjects
		send_item(wgm_pkg::CMD_END, 8'h00, 1'b0);
		send_item(wgm_pkg::CMD_SUBJECT, 8'h00, 1'b1);
		// pattern A**? : star after star, question mark after star
		send_item(wgm_pkg::CMD_APPEND, "A", 1'b1);
		send_item(wgm_pkg::CMD_APPEND, wgm_pkg::STAR_CHAR, 1'b0);
		send_item(wgm_pkg::CMD_APPEND, wgm_pkg::STAR_CHAR, 1'b0);
		send_item(wgm_pkg::CMD_APPEND, wgm_pkg::QMARK_CHAR, 1'b0);
		send_item(wgm_pkg::CMD_SUBJECT, "A", 1'b0);
		send_item(wgm_pkg::CMD_SUBJECT, 8'hFF, 1'b0);
		send_item(wgm_pkg::CMD_SUBJECT, 8'hFF, 1'b1);
		send_item(wgm_pkg::CMD_SUBJECT, "A", 1'b1);
		// end command in the middle of a subject
		send_item(wgm_pkg::CMD_SUBJECT, "A", 1'b0);
		send_item(wgm_pkg::CMD_END, 8'hFF, 1'b1);
		// append during a subject drops it
		send_item(wgm_pkg::CMD_SUBJECT, "A", 1'b0);
		send_item(wgm_pkg::CMD_APPEND, "Z", 1'b0);
		send_item(wgm_pkg::CMD_SUBJECT, "A", 1'b0);
		send_item(wgm_pkg::CMD_SUBJECT, wgm_pkg::QMARK_CHAR, 1'b0);
		send_item(wgm_pkg::CMD_SUBJECT, "Z", 1'b1);
		// clear during a subject, then the empty subject again
		send_item(wgm_pkg::CMD_SUBJECT, "a", 1'b0);
		send_item(wgm_pkg::CMD_CLEAR, 8'hFF, 1'b1);
		send_item(wgm_pkg::CMD_END, 8'h55, 1'b1);

		// folded compares, sender idles less than receiver
		drain();
		write_case_mode(1'b0);
		run_phase(410);

		// exact compares, idling swapped, one full pause half way
		drain();
		tx_idle_pct = 50;
		rx_idle_pct = 34;
		write_case_mode(1'b1);
		run_phase(200);
		drain();
		run_phase(210);

		// folded again, no idling, receiver holds off to back the block up
		drain();
		tx_idle_pct = 0;
		rx_idle_pct = 0;
		write_case_mode(1'b0);
		hold_req = 1'b1;
		run_phase(410);

		drain();
		if (mismatch_count == 0) begin
			$display("All tests passed");
		end else begin
			$display("Some tests failed");
		end
		$finish;
	end

endmodule
